>>> sv/frs_pkg.sv
`timescale 1ns / 1ps
package frs_pkg;

    localparam int WINDOW_LEN  = 32;
    localparam int NUM_ENTRIES = 16;

    localparam int KIND_W    = 2;
    localparam int BYTE_W    = 8;
    localparam int EIDX_W    = 4;
    localparam int CPOS_W    = 5;
    localparam int POS_W     = 32;
    localparam int FOUND_W   = 16;
    localparam int MASK_W    = 64;
    localparam int NUM_MASKS = 4;
    localparam int CFG_IDX_W = 2;
    localparam int RUN_W     = $clog2(WINDOW_LEN + 1);

    localparam int S_FIELD_W = BYTE_W + EIDX_W + CPOS_W;
    localparam int S_TDATA_W = ((S_FIELD_W + 7) / 8) * 8;
    localparam int M_FIELD_W = EIDX_W + POS_W + FOUND_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - M_FIELD_W;

    typedef enum logic [KIND_W-1:0] {
        KIND_SCAN  = 2'd0,
        KIND_LOAD  = 2'd1,
        KIND_CLEAR = 2'd2
    } kind_t;

    typedef logic [WINDOW_LEN-1:0][BYTE_W-1:0] window_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] byte_value;
        logic [EIDX_W-1:0] entry_index;
        logic [CPOS_W-1:0] char_position;
    } item_t;

    typedef struct packed {
        logic             full;
        logic [POS_W-1:0] pos;
    } scan_info_t;

    typedef struct packed {
        logic              hit;
        logic [EIDX_W-1:0] hit_entry;
    } match_t;

endpackage

>>> sv/frs_window.sv
`timescale 1ns / 1ps
module frs_window import frs_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [MASK_W-1:0]    cfg_data,
    input  logic                 proc_en,
    input  item_t                item,
    output window_t              win_next,
    output scan_info_t           info
);

    logic [NUM_MASKS-1:0][MASK_W-1:0] mask_reg;
    window_t                          win_reg;
    logic [RUN_W-1:0]                 run_reg;
    logic [RUN_W-1:0]                 run_next;
    logic [POS_W-1:0]                 pos_reg;
    logic [POS_W-1:0]                 pos_next;
    logic                             in_class;

    always_comb begin
        in_class = mask_reg[item.byte_value[7:6]][item.byte_value[5:0]];
        for (int i = 0; i < WINDOW_LEN - 1; i++) begin
            win_next[i] = win_reg[i+1];
        end
        win_next[WINDOW_LEN-1] = item.byte_value;
        if (!in_class) begin
            run_next = '0;
        end else if (run_reg == RUN_W'(WINDOW_LEN)) begin
            run_next = run_reg;
        end else begin
            run_next = run_reg + RUN_W'(1);
        end
        pos_next  = pos_reg + POS_W'(1);
        info.full = (run_next == RUN_W'(WINDOW_LEN));
        info.pos  = pos_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
            win_reg  <= '0;
            run_reg  <= '0;
            pos_reg  <= '0;
        end else begin
            if (cfg_wr) begin
                mask_reg[cfg_index] <= cfg_data;
            end
            if (proc_en) begin
                case (item.kind)
                    KIND_SCAN: begin
                        win_reg <= win_next;
                        run_reg <= run_next;
                        pos_reg <= pos_next;
                    end
                    KIND_CLEAR: begin
                        win_reg <= '0;
                        run_reg <= '0;
                        pos_reg <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

>>> sv/frs_match.sv
`timescale 1ns / 1ps
module frs_match import frs_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               proc_en,
    input  item_t              item,
    input  window_t            win_next,
    input  logic               full,
    output match_t             match,
    output logic [FOUND_W-1:0] found_mask
);

    window_t                pat_reg [NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0] valid_reg;
    logic [NUM_ENTRIES-1:0] valid_next;
    logic [NUM_ENTRIES-1:0] found_reg;
    logic [NUM_ENTRIES-1:0] found_next;
    logic [NUM_ENTRIES-1:0] cand;
    logic [NUM_ENTRIES-1:0] sel;
    logic                   load_ok;
    logic                   is_scan;

    always_comb begin
        is_scan = (item.kind == KIND_SCAN);
        load_ok = (item.kind == KIND_LOAD) && (int'(item.entry_index) < NUM_ENTRIES)
                  && (int'(item.char_position) < WINDOW_LEN);
        for (int e = 0; e < NUM_ENTRIES; e++) begin
            cand[e] = valid_reg[e] && !found_reg[e] && (pat_reg[e] == win_next)
                      && is_scan && full;
        end
        // lowest set candidate wins
        sel = cand & (~cand + NUM_ENTRIES'(1));
        match.hit       = |cand;
        match.hit_entry = '0;
        for (int e = NUM_ENTRIES - 1; e >= 0; e--) begin
            if (cand[e]) begin
                match.hit_entry = EIDX_W'(e);
            end
        end
        valid_next = valid_reg;
        for (int e = 0; e < NUM_ENTRIES; e++) begin
            if (load_ok && int'(item.entry_index) == e) begin
                valid_next[e] = 1'b1;
            end
        end
        case (item.kind)
            KIND_SCAN: begin
                found_next = found_reg | sel;
            end
            KIND_CLEAR: begin
                found_next = '0;
                valid_next = '0;
            end
            default: begin
                found_next = found_reg;
            end
        endcase
    end

    for (genvar i = 0; i < FOUND_W; i++) begin : g_found
        if (i < NUM_ENTRIES) begin : g_used
            assign found_mask[i] = found_next[i];
        end else begin : g_unused
            assign found_mask[i] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        for (int e = 0; e < NUM_ENTRIES; e++) begin
            for (int p = 0; p < WINDOW_LEN; p++) begin
                if (proc_en && load_ok && int'(item.entry_index) == e
                    && int'(item.char_position) == p) begin
                    pat_reg[e][p] <= item.byte_value;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            found_reg <= '0;
        end else if (proc_en) begin
            valid_reg <= valid_next;
            found_reg <= found_next;
        end
    end

    // found marks only drop on a clear
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(proc_en && item.kind == KIND_CLEAR)
        |=> (found_reg & $past(found_reg)) == $past(found_reg))
        else $error("found mark lost without clear");

    // a found entry must have been loaded
    assert property (@(posedge aclk) disable iff (!aresetn)
        (found_reg & ~valid_reg) == '0)
        else $error("found mark on unloaded entry");

endmodule

>>> sv/fixed_length_reference_scanner.sv
`timescale 1ns / 1ps
// channel | dir | handshake              | payload
// s_      | in  | s_tvalid / s_tready    | s_tdata: byte_value, entry_index, char_position
//         |     |                        | s_tuser: kind
// m_      | out | m_tvalid / m_tready    | m_tdata: hit_entry, hit_offset, found_mask
//         |     |                        | m_tuser: hit
// cfg_    | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data (class masks 0..3)
//
// one beat per cycle sustained while m_tready is high; each result passes the input register,
// then the parallel window compare into the result register
// aresetn is synchronous; it clears the class masks, window, table marks and position
// a stalled m_ side holds the result; the input register still takes one more beat
// cfg_ready is always high
module fixed_length_reference_scanner import frs_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // byte_value, entry_index, char_position
    input  logic [KIND_W-1:0]    s_tuser,   // kind
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // hit_entry, hit_offset, found_mask
    output logic [0:0]           m_tuser,   // hit
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [MASK_W-1:0]    cfg_data
);

    logic                 in_valid_reg;
    item_t                in_item_reg;
    item_t                in_item_next;
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic [M_TDATA_W-1:0] out_data_next;
    logic                 out_user_reg;
    logic                 advance;
    window_t              win_next;
    scan_info_t           info;
    match_t               match;
    logic [FOUND_W-1:0]   found_mask;
    logic [POS_W-1:0]     hit_offset;
    logic [EIDX_W-1:0]    out_entry;
    logic [FOUND_W-1:0]   out_found;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_user_reg;

    always_comb begin
        in_item_next.kind          = s_tuser;
        in_item_next.byte_value    = s_tdata[BYTE_W-1:0];
        in_item_next.entry_index   = s_tdata[BYTE_W+EIDX_W-1:BYTE_W];
        in_item_next.char_position = s_tdata[S_FIELD_W-1:BYTE_W+EIDX_W];
        hit_offset    = match.hit ? (info.pos - POS_W'(WINDOW_LEN - 1)) : '0;
        out_data_next = {{M_PAD_W{1'b0}}, found_mask, hit_offset, match.hit_entry};
        out_entry     = out_data_reg[EIDX_W-1:0];
        out_found     = out_data_reg[M_FIELD_W-1:EIDX_W+POS_W];
    end

    frs_window u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .proc_en   (advance),
        .item      (in_item_reg),
        .win_next  (win_next),
        .info      (info)
    );

    frs_match u_match (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .proc_en    (advance),
        .item       (in_item_reg),
        .win_next   (win_next),
        .full       (info.full),
        .match      (match),
        .found_mask (found_mask)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= in_item_next;
        end
        if (advance) begin
            out_data_reg <= out_data_next;
            out_user_reg <= match.hit;
        end
    end

    // a held input beat is not overwritten while the result side is stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_item_reg))
        else $error("held input beat changed");

    // a reported hit always has its entry marked found
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_user_reg |-> out_found[out_entry])
        else $error("hit entry not in found mask");

    // hits only come from scan beats that close a full class window
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && match.hit |-> info.full && in_item_reg.kind == KIND_SCAN)
        else $error("hit without full scan window");

    // non-hit results carry zero entry and offset
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_user_reg |-> out_data_reg[EIDX_W+POS_W-1:0] == '0)
        else $error("stale hit fields");

endmodule
